// ===== src/assert_macros.svh =====
// assertion helpers used by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising clock edge, ignored during reset
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// property checked at every rising clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

// ===== src/skmp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package skmp_pkg;

  localparam int MAX_K = 31;
  localparam int MAX_M = 8;
  localparam int KW = 2 * MAX_K;
  localparam int MW = 2 * MAX_M;
  localparam int QDEPTH = 4;
  localparam int QAW = $clog2(QDEPTH);

  localparam logic [MW-1:0] ABSENT_MINIMIZER = MW'(3);

  localparam logic CFG_KMER_LENGTH = 1'b0;
  localparam logic CFG_MMER_LENGTH = 1'b1;

  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_PARTITION = 1'b1;

  typedef struct packed {
    logic cmd;
    logic first;
    logic final_b;
    logic act;
    logic [31:0] bases;
    logic [KW-1:0] val;
  } job_t;

  typedef struct packed {
    logic present;
    logic [15:0] count;
  } tab_entry_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_CNT_RD,
    B_CNT_UPD,
    B_WALK,
    B_DECIDE,
    B_EMIT1,
    B_EMIT2
  } back_state_t;

  function automatic logic [4:0] eff_k(input logic [4:0] k);
    logic [4:0] r;
    r = k;
    if (k < 5'd2) r = 5'd2;
    if (k > 5'(MAX_K)) r = 5'(MAX_K);
    return r;
  endfunction

  function automatic logic [3:0] eff_m(input logic [3:0] m, input logic [4:0] k);
    logic [3:0] r;
    r = m;
    if (m < 4'd1) r = 4'd1;
    if (m > 4'(MAX_M)) r = 4'(MAX_M);
    if ({1'b0, r} > k) r = k[3:0];
    return r;
  endfunction

  function automatic logic [MW-1:0] mmer_mask(input logic [3:0] m);
    return {MW{1'b1}} >> (5'(MW) - {m, 1'b0});
  endfunction

  function automatic logic [MW-1:0] canon_mmer(input logic [MW-1:0] v, input logic [3:0] m);
    logic [MW-1:0] r8;
    logic [MW-1:0] r;
    for (int j = 0; j < MAX_M; j++) begin
      r8[2*j +: 2] = ~v[2*(MAX_M-1-j) +: 2];
    end
    r = r8 >> (5'(MW) - {m, 1'b0});
    return (v < r) ? v : r;
  endfunction

endpackage
`default_nettype wire

// ===== src/skmp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
module skmp_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              accept,
  input  wire logic              cmd,
  input  wire logic [1:0]        nucleotide,
  input  wire logic              seq_first,
  input  wire logic              seq_final,
  input  wire logic [4:0]        k,
  input  wire logic [3:0]        m,
  output skmp_pkg::job_t         job
);
  import skmp_pkg::*;

  logic [KW-1:0] fk, rk, fk0, rk0, fk_next, rk_next, kmask, canon;
  logic [MW-1:0] rm, rm0, rm_next, mmask, fm, cmm;
  logic [31:0] bases, bases0, bases_next;
  logic [5:0] k2;
  logic [4:0] m2;
  logic [1:0] comp;

  always_comb begin
    k2 = {k, 1'b0};
    m2 = {m, 1'b0};
    kmask = {KW{1'b1}} >> (6'(KW) - k2);
    mmask = mmer_mask(m);
    fk0 = seq_first ? '0 : fk;
    rk0 = seq_first ? '0 : rk;
    rm0 = seq_first ? '0 : rm;
    bases0 = seq_first ? '0 : bases;
    comp = ~nucleotide;
    fk_next = {fk0[KW-3:0], nucleotide} & kmask;
    rk_next = ((rk0 & kmask) >> 2) | (KW'(comp) << (k2 - 6'd2));
    rm_next = ((rm0 & mmask) >> 2) | (MW'(comp) << (m2 - 5'd2));
    bases_next = (bases0 == '1) ? bases0 : bases0 + 32'd1;
    fm = fk_next[MW-1:0] & mmask;
    cmm = (fm < rm_next) ? fm : rm_next;
    canon = (fk_next < rk_next) ? fk_next : rk_next;
    job.cmd = cmd;
    job.first = seq_first;
    job.final_b = seq_final;
    job.bases = bases_next;
    job.act = (cmd == CMD_PARTITION) ? (bases_next >= 32'(k)) : (bases_next >= 32'(m));
    job.val = (cmd == CMD_PARTITION) ? canon : KW'(cmm);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fk <= '0;
      rk <= '0;
      rm <= '0;
      bases <= '0;
    end else if (accept) begin
      fk <= fk_next;
      rk <= rk_next;
      rm <= rm_next;
      bases <= seq_final ? '0 : bases_next;
    end
  end

endmodule
`default_nettype wire

// ===== src/skmp_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
module skmp_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  skmp_pkg::job_t      push_data,
  input  wire logic           pop,
  output skmp_pkg::job_t      head,
  output logic                empty,
  output logic                full
);
  import skmp_pkg::*;

  job_t mem [QDEPTH];
  logic [QAW-1:0] wptr, rptr;
  logic [QAW:0] fill;

  assign empty = (fill == '0);
  assign full = (fill == (QAW+1)'(QDEPTH));
  assign head = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop) rptr <= rptr + 1'b1;
      if (push && !pop) fill <= fill + 1'b1;
      else if (pop && !push) fill <= fill - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== src/skmp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
module skmp_back (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  skmp_pkg::job_t            head,
  input  wire logic                 empty,
  output logic                      pop,
  input  wire logic [4:0]           k,
  input  wire logic [3:0]           m,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [15:0]               minimizer_id,
  output logic [31:0]               segment_start,
  output logic [31:0]               segment_length,
  output logic                      last_of_run,
  output skmp_pkg::back_status_t    status
);
  import skmp_pkg::*;

  back_state_t state, state_next;

  tab_entry_t tab_mem [1 << MW];
  tab_entry_t rd_data, wr_data, upd_entry;
  logic mem_re, mem_we;
  logic [MW-1:0] raddr, waddr, clr_addr;

  job_t job;
  logic [KW-1:0] x;
  logic [4:0] issue_cnt, n_reads;
  logic issue_ok, pend, pend_first, pend_last;
  logic [MW-1:0] pend_val, walk_mmer;
  logic [MW-1:0] mini_val, mini_res, new_val;
  logic [15:0] mini_cnt, new_cnt;
  logic mini_pres, new_pres, better, abort_walk;

  logic [MW-1:0] cur;
  logic [31:0] open_start, pos, os1, len2;
  logic act_p, chg, has1_c, has2_c, has2;
  logic [MW-1:0] r1_min, r2_min;
  logic [31:0] r1_start, r1_len, r2_start, r2_len;
  logic slot_free, out_load, emit_second;

  assign status.clearing = (state == B_CLEAR);
  assign slot_free = !out_valid || !out_stall;

  // walk over the m-mers of the canonical k-mer
  always_comb begin
    n_reads = k - 5'(m) + 5'd1;
    issue_ok = issue_cnt < n_reads;
    walk_mmer = canon_mmer(x[MW-1:0] & mmer_mask(m), m);
    better = (mini_cnt > rd_data.count) ||
             ((mini_cnt == rd_data.count) && (pend_val < mini_val));
    abort_walk = !pend_first && (!mini_pres || !rd_data.present);
    if (pend_first || better) begin
      new_val = pend_val;
      new_cnt = rd_data.count;
      new_pres = rd_data.present;
    end else begin
      new_val = mini_val;
      new_cnt = mini_cnt;
      new_pres = mini_pres;
    end
  end

  always_comb begin
    if (!rd_data.present) upd_entry = '{present: 1'b1, count: 16'd0};
    else if (rd_data.count != '1) upd_entry = '{present: 1'b1, count: rd_data.count + 16'd1};
    else upd_entry = rd_data;
  end

  // segment bookkeeping
  always_comb begin
    act_p = (job.cmd == CMD_PARTITION) && (job.bases >= 32'(k));
    pos = job.bases - 32'd1;
    chg = act_p && (job.bases != 32'(k)) && (mini_res != cur);
    os1 = chg ? (pos - 32'(k) + 32'd1) : open_start;
    len2 = job.bases - os1;
    has1_c = chg;
    has2_c = act_p && job.final_b && (len2 >= 32'(k));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_CLEAR: if (clr_addr == '1) state_next = B_IDLE;
      B_IDLE: begin
        if (!empty) begin
          if (!head.act) state_next = B_DECIDE;
          else if (head.cmd == CMD_PARTITION) state_next = B_WALK;
          else state_next = B_CNT_RD;
        end
      end
      B_CNT_RD: state_next = B_CNT_UPD;
      B_CNT_UPD: state_next = B_DECIDE;
      B_WALK: if (pend && (abort_walk || pend_last)) state_next = B_DECIDE;
      B_DECIDE: begin
        if (has1_c) state_next = B_EMIT1;
        else if (has2_c) state_next = B_EMIT2;
        else state_next = B_IDLE;
      end
      B_EMIT1: if (slot_free) state_next = has2 ? B_EMIT2 : B_IDLE;
      B_EMIT2: if (slot_free) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop = 1'b0;
    mem_re = 1'b0;
    raddr = job.val[MW-1:0];
    mem_we = 1'b0;
    waddr = job.val[MW-1:0];
    wr_data = upd_entry;
    out_load = 1'b0;
    emit_second = 1'b0;
    unique case (state)
      B_CLEAR: begin
        mem_we = 1'b1;
        waddr = clr_addr;
        wr_data = '0;
      end
      B_IDLE: pop = !empty;
      B_CNT_RD: mem_re = 1'b1;
      B_CNT_UPD: mem_we = 1'b1;
      B_WALK: begin
        mem_re = issue_ok;
        raddr = walk_mmer;
      end
      B_DECIDE: ;
      B_EMIT1: out_load = slot_free;
      B_EMIT2: begin
        out_load = slot_free;
        emit_second = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) tab_mem[waddr] <= wr_data;
    if (mem_re) rd_data <= tab_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_CLEAR;
      clr_addr <= '0;
      cur <= '0;
      open_start <= '0;
      out_valid <= 1'b0;
      pend <= 1'b0;
      issue_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == B_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (pop) begin
        job <= head;
        x <= head.val;
        issue_cnt <= '0;
        pend <= 1'b0;
        if (head.first) open_start <= '0;
      end
      if (state == B_WALK) begin
        pend <= issue_ok;
        if (issue_ok) begin
          x <= x >> 2;
          issue_cnt <= issue_cnt + 5'd1;
          pend_first <= (issue_cnt == '0);
          pend_last <= (issue_cnt == n_reads - 5'd1);
          pend_val <= walk_mmer;
        end
        if (pend) begin
          mini_val <= new_val;
          mini_cnt <= new_cnt;
          mini_pres <= new_pres;
          mini_res <= abort_walk ? ABSENT_MINIMIZER : new_val;
        end
      end
      if (state == B_DECIDE) begin
        r1_min <= cur;
        r1_start <= open_start;
        r1_len <= pos - open_start;
        r2_min <= act_p ? mini_res : cur;
        r2_start <= os1;
        r2_len <= len2;
        has2 <= has2_c;
        if (act_p) cur <= mini_res;
        open_start <= job.final_b ? '0 : os1;
      end
      if (out_load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      minimizer_id <= emit_second ? r2_min : r1_min;
      segment_start <= emit_second ? r2_start : r1_start;
      segment_length <= emit_second ? r2_len : r1_len;
      last_of_run <= emit_second ? 1'b1 : !has2;
    end
  end

endmodule
`default_nettype wire

// ===== src/super_kmer_minimizer_partition_core.sv =====
// super-k-mer minimizer partitioner
// input channel: one nucleotide per transaction (in_valid / in_stall) with cmd,
//   seq_first and seq_final; cmd 0 counts m-mer abundances, cmd 1 partitions.
// output channel: super-k-mer transactions (out_valid / out_stall) carrying
//   minimizer_id, segment_start, segment_length and last_of_run; a partition
//   step gives zero, one or two of them.
// config: cfg_we writes cfg_data into register cfg_index (0 kmer_length,
//   1 mmer_length); write only while the block is idle.
// table use: a count step reads and updates one abundance table entry; a
//   partition step does one abundance table read per m-mer of the k-mer,
//   limited by the single table read port, then emits its super-k-mers.
// the front updates the rolling registers and queues up to 4 steps, so input
//   is taken while the back walks a k-mer.
// reset (rst, synchronous) starts a clearing pass over all 65536 entries of
//   the abundance table; in_stall stays high until it ends.
// when out_stall is high the result holds and the back waits; the queue keeps
//   taking input until full.
`timescale 1ns / 1ps
`default_nettype none
module super_kmer_minimizer_partition_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [4:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        cmd,
  input  wire logic [1:0]  nucleotide,
  input  wire logic        seq_first,
  input  wire logic        seq_final,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      minimizer_id,
  output logic [31:0]      segment_start,
  output logic [31:0]      segment_length,
  output logic             last_of_run
);
  import skmp_pkg::*;

  logic [4:0] kmer_length, k;
  logic [3:0] mmer_length, m;
  logic accept, pop, empty, full;
  job_t push_job, head;
  back_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length <= 5'd31;
      mmer_length <= 4'd8;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KMER_LENGTH: kmer_length <= cfg_data;
        CFG_MMER_LENGTH: mmer_length <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  assign k = eff_k(kmer_length);
  assign m = eff_m(mmer_length, k);
  assign in_stall = full || status.clearing;
  assign accept = in_valid && !in_stall;

  skmp_front u_front (
    .clk(clk), .rst(rst), .accept(accept), .cmd(cmd), .nucleotide(nucleotide),
    .seq_first(seq_first), .seq_final(seq_final), .k(k), .m(m), .job(push_job)
  );

  skmp_fifo u_fifo (
    .clk(clk), .rst(rst), .push(accept), .push_data(push_job), .pop(pop),
    .head(head), .empty(empty), .full(full)
  );

  skmp_back u_back (
    .clk(clk), .rst(rst), .head(head), .empty(empty), .pop(pop), .k(k), .m(m),
    .out_valid(out_valid), .out_stall(out_stall), .minimizer_id(minimizer_id),
    .segment_start(segment_start), .segment_length(segment_length),
    .last_of_run(last_of_run), .status(status)
  );

endmodule
`default_nettype wire

// ===== src/skmp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module skmp_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] minimizer_id,
  input wire logic [31:0] segment_start,
  input wire logic [31:0] segment_length,
  input wire logic        last_of_run
);

  logic [80:0] out_word;
  assign out_word = {minimizer_id, segment_start, segment_length, last_of_run};

  `ASSERT_CLK(out_held, clk, rst, out_valid && out_stall |=> out_valid)
  `ASSERT_CLK(out_stable, clk, rst, out_valid && out_stall |=> $stable(out_word))
  `ASSERT_ALWAYS(stall_after_reset, clk, rst |=> in_stall)
  `ASSERT_ALWAYS(no_out_after_reset, clk, rst |=> !out_valid)

endmodule

bind super_kmer_minimizer_partition_core skmp_checker u_chk (.*);
`default_nettype wire
